### hdl/greedy_text_wrapper_macros.svh
// ----------------------------------------------------------------------------
// Greedy text wrapper assertion macros
// Concurrent checks for the wrapper, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef GREEDY_TEXT_WRAPPER_MACROS_SVH
`define GREEDY_TEXT_WRAPPER_MACROS_SVH

`ifndef SYNTHESIS
// check that holds on every edge out of reset
`define GTW_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("greedy_text_wrapper check failed");
// antecedent on one edge, consequent on the next
`define GTW_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("greedy_text_wrapper sequence check failed");
`else
`define GTW_ASSERT(lbl, prop)
`define GTW_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

### hdl/gtw_pkg.sv
// ----------------------------------------------------------------------------
// Greedy text wrapper package
// Shared constants, result codes and the row chain control word.
// ----------------------------------------------------------------------------
package gtw_pkg;

  localparam int MAX_COLS = 30;
  localparam int MAX_ROWS = 16;
  localparam int COL_W    = $clog2(MAX_COLS + 1);

  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;

  localparam logic [1:0] KIND_BYTE   = 2'd0;
  localparam logic [1:0] KIND_DONE   = 2'd1;
  localparam logic [1:0] KIND_REFUSE = 2'd2;

  localparam logic [1:0] CFG_ROW_WIDTH    = 2'd0;
  localparam logic [1:0] CFG_ROW_LIMIT    = 2'd1;
  localparam logic [1:0] CFG_OUT_CAPACITY = 2'd2;

  localparam logic [4:0]  RST_ROW_WIDTH    = 5'd30;
  localparam logic [4:0]  RST_ROW_LIMIT    = 5'd16;
  localparam logic [10:0] RST_OUT_CAPACITY = 11'd512;

  typedef struct packed {
    logic             shift;
    logic             wr;
    logic [COL_W-1:0] widx;
    logic [7:0]       wdata;
  } chain_ctl_t;

endpackage

### hdl/gtw_cell.sv
// ----------------------------------------------------------------------------
// Greedy text wrapper row cell
// One column of the row: loads a byte at its index or takes its neighbour's.
// ----------------------------------------------------------------------------
module gtw_cell (
  input  logic                     clk_i,
  input  gtw_pkg::chain_ctl_t      ctl_i,
  input  logic [gtw_pkg::COL_W-1:0] idx_i,
  input  logic [7:0]               nxt_i,
  output logic [7:0]               q_o
);

  logic [7:0] data_q;
  logic [7:0] data_d;

  always_comb begin
    data_d = data_q;
    if (ctl_i.wr && (ctl_i.widx == idx_i)) begin
      data_d = ctl_i.wdata;
    end else if (ctl_i.shift) begin
      data_d = nxt_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign q_o = data_q;

endmodule

### hdl/gtw_chain.sv
// ----------------------------------------------------------------------------
// Greedy text wrapper row chain
// Row of cells; a shift moves every byte one column towards the front.
// ----------------------------------------------------------------------------
module gtw_chain (
  input  logic                clk_i,
  input  gtw_pkg::chain_ctl_t ctl_i,
  output logic [7:0]          front_o
);

  logic [7:0] cell_q [gtw_pkg::MAX_COLS];

  for (genvar i = 0; i < gtw_pkg::MAX_COLS; i++) begin : g_cell
    logic [7:0] nxt;
    if (i == gtw_pkg::MAX_COLS - 1) begin : g_tail
      assign nxt = 8'h00;
    end else begin : g_body
      assign nxt = cell_q[i+1];
    end
    gtw_cell u_cell (
      .clk_i (clk_i),
      .ctl_i (ctl_i),
      .idx_i (gtw_pkg::COL_W'(i)),
      .nxt_i (nxt),
      .q_o   (cell_q[i])
    );
  end

  assign front_o = cell_q[0];

endmodule

### hdl/greedy_text_wrapper.sv
// ----------------------------------------------------------------------------
// Greedy text wrapper
// Text comes in one byte a word on the input channel (valid/stall) and leaves
// wrapped into rows, one result a word on the output channel: row bytes and
// newlines, then a finish word with the row count, or a refusal word.
// Configuration: row width, row limit, output capacity, written by index.
// An ordinary byte is accepted and then decided. Closing a row takes the
// decide step, any newline and then the row bytes, sent as the row chain
// shifts the row out through its front cell; a break at a space adds a
// step to drop the space and append the byte. End of text adds a check
// step, the last row and the finish word. Results leave through a register.
// A stalled output holds the sequencer; input is taken only while idle.
// Reset clears the run state and loads the register defaults; no row store
// clearing is needed.
// ----------------------------------------------------------------------------
module greedy_text_wrapper (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  char_byte_i,
  input  logic        is_final_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  out_byte_o,
  output logic [4:0]  row_count_o,
  output logic        run_end_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [10:0] cfg_data_i
);

  `include "greedy_text_wrapper_macros.svh"

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DEC  = 3'd1;
  localparam logic [2:0] ST_FIN  = 3'd2;
  localparam logic [2:0] ST_NL   = 3'd3;
  localparam logic [2:0] ST_ROW  = 3'd4;
  localparam logic [2:0] ST_DROP = 3'd5;
  localparam logic [2:0] ST_DONE = 3'd6;
  localparam logic [2:0] ST_REF  = 3'd7;

  localparam logic [1:0] POST_CLEAR = 2'd0;
  localparam logic [1:0] POST_BREAK = 2'd1;
  localparam logic [1:0] POST_FIN   = 2'd2;

  localparam logic [4:0] COLS_MAX = 5'(gtw_pkg::MAX_COLS);
  localparam logic [4:0] ROWS_MAX = 5'(gtw_pkg::MAX_ROWS);

  logic [2:0]  state_q, state_d;
  logic [4:0]  row_width_q, row_limit_q;
  logic [10:0] out_capacity_q;

  logic [7:0]  c_q, c_d;
  logic        fin_q, fin_d;
  logic [4:0]  len_q, len_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [1:0]  post_q, post_d;

  logic [4:0]  row_fill_q, row_fill_d;
  logic [4:0]  space_pos_q, space_pos_d;
  logic        space_seen_q, space_seen_d;
  logic [4:0]  rows_done_q, rows_done_d;
  logic [10:0] bytes_done_q, bytes_done_d;
  logic        refused_q, refused_d;

  logic        out_valid_q;
  logic [1:0]  kind_q, kind_d;
  logic [7:0]  byte_q, byte_d;
  logic [4:0]  count_q, count_d;
  logic        end_q, end_d;
  logic        emit;
  logic        out_free;

  gtw_pkg::chain_ctl_t ctl;
  logic [7:0]  front;

  logic [4:0]  cols, lim;
  logic [4:0]  fit_len;
  logic        nl;
  logic [5:0]  need;
  logic [11:0] fit_sum;
  logic        fits;
  logic [4:0]  rem;

  gtw_chain u_chain (
    .clk_i   (clk_i),
    .ctl_i   (ctl),
    .front_o (front)
  );

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_free    = !out_valid_q || !out_stall_i;

  assign cols    = (row_width_q > COLS_MAX) ? COLS_MAX : row_width_q;
  assign lim     = (row_limit_q > ROWS_MAX) ? ROWS_MAX : row_limit_q;
  assign fit_len = ((state_q == ST_DEC) && (c_q != gtw_pkg::CH_SPACE)) ?
                   space_pos_q : row_fill_q;
  assign nl      = (rows_done_q != 5'd0);
  assign need    = {1'b0, fit_len} + {5'd0, nl};
  assign fit_sum = {1'b0, bytes_done_q} + {6'd0, need};
  assign fits    = (rows_done_q < lim) && (fit_sum < {1'b0, out_capacity_q});
  assign rem     = row_fill_q - space_pos_q - 5'd1;

  always_comb begin
    state_d      = state_q;
    c_d          = c_q;
    fin_d        = fin_q;
    len_d        = len_q;
    cnt_d        = cnt_q;
    post_d       = post_q;
    row_fill_d   = row_fill_q;
    space_pos_d  = space_pos_q;
    space_seen_d = space_seen_q;
    rows_done_d  = rows_done_q;
    bytes_done_d = bytes_done_q;
    refused_d    = refused_q;
    emit         = 1'b0;
    kind_d       = gtw_pkg::KIND_BYTE;
    byte_d       = 8'h00;
    count_d      = 5'd0;
    end_d        = 1'b0;
    ctl          = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          c_d     = char_byte_i;
          fin_d   = is_final_i;
          state_d = ST_DEC;
        end
      end
      ST_DEC: begin
        if (refused_q) begin
          if (fin_q) begin
            row_fill_d   = '0;
            space_pos_d  = '0;
            space_seen_d = 1'b0;
            rows_done_d  = '0;
            bytes_done_d = '0;
            refused_d    = 1'b0;
          end
          state_d = ST_IDLE;
        end else if (c_q == gtw_pkg::CH_NEWLINE) begin
          state_d = ST_REF;
        end else if ((row_fill_q == 5'd0) && (c_q == gtw_pkg::CH_SPACE)) begin
          state_d = fin_q ? ST_FIN : ST_IDLE;
        end else if (row_fill_q >= cols) begin
          if ((c_q != gtw_pkg::CH_SPACE) &&
              (!space_seen_q || (space_pos_q >= row_fill_q))) begin
            state_d = ST_REF;
          end else if (fits) begin
            len_d        = fit_len;
            cnt_d        = '0;
            post_d       = (c_q == gtw_pkg::CH_SPACE) ? POST_CLEAR : POST_BREAK;
            bytes_done_d = bytes_done_q + 11'(need);
            rows_done_d  = rows_done_q + 5'd1;
            state_d      = nl ? ST_NL : ST_ROW;
          end else begin
            state_d = ST_REF;
          end
        end else begin
          if (c_q == gtw_pkg::CH_SPACE) begin
            space_pos_d  = row_fill_q;
            space_seen_d = 1'b1;
          end
          if (row_fill_q < COLS_MAX) begin
            ctl.wr     = 1'b1;
            ctl.widx   = row_fill_q;
            ctl.wdata  = c_q;
            row_fill_d = row_fill_q + 5'd1;
          end
          state_d = fin_q ? ST_FIN : ST_IDLE;
        end
      end
      ST_FIN: begin
        if (row_fill_q == 5'd0) begin
          state_d = ST_DONE;
        end else if (fits) begin
          len_d        = fit_len;
          cnt_d        = '0;
          post_d       = POST_FIN;
          bytes_done_d = bytes_done_q + 11'(need);
          rows_done_d  = rows_done_q + 5'd1;
          state_d      = nl ? ST_NL : ST_ROW;
        end else begin
          state_d = ST_REF;
        end
      end
      ST_NL: begin
        if (out_free) begin
          emit    = 1'b1;
          byte_d  = gtw_pkg::CH_NEWLINE;
          state_d = ST_ROW;
        end
      end
      ST_ROW: begin
        if (out_free) begin
          emit      = 1'b1;
          byte_d    = front;
          ctl.shift = 1'b1;
          cnt_d     = cnt_q + 5'd1;
          if (cnt_q == (len_q - 5'd1)) begin
            end_d = !fin_q;
            case (post_q)
              POST_CLEAR: begin
                row_fill_d   = '0;
                space_seen_d = 1'b0;
                state_d      = fin_q ? ST_FIN : ST_IDLE;
              end
              POST_BREAK: state_d = ST_DROP;
              default:    state_d = ST_DONE;
            endcase
          end
        end
      end
      ST_DROP: begin
        ctl.shift    = 1'b1;
        ctl.wr       = 1'b1;
        ctl.widx     = rem;
        ctl.wdata    = c_q;
        row_fill_d   = rem + 5'd1;
        space_seen_d = 1'b0;
        space_pos_d  = '0;
        state_d      = fin_q ? ST_FIN : ST_IDLE;
      end
      ST_DONE: begin
        if (out_free) begin
          emit         = 1'b1;
          kind_d       = gtw_pkg::KIND_DONE;
          count_d      = rows_done_q;
          end_d        = 1'b1;
          row_fill_d   = '0;
          space_pos_d  = '0;
          space_seen_d = 1'b0;
          rows_done_d  = '0;
          bytes_done_d = '0;
          refused_d    = 1'b0;
          state_d      = ST_IDLE;
        end
      end
      ST_REF: begin
        if (out_free) begin
          emit      = 1'b1;
          kind_d    = gtw_pkg::KIND_REFUSE;
          end_d     = 1'b1;
          refused_d = 1'b1;
          if (fin_q) begin
            row_fill_d   = '0;
            space_pos_d  = '0;
            space_seen_d = 1'b0;
            rows_done_d  = '0;
            bytes_done_d = '0;
            refused_d    = 1'b0;
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      row_width_q    <= gtw_pkg::RST_ROW_WIDTH;
      row_limit_q    <= gtw_pkg::RST_ROW_LIMIT;
      out_capacity_q <= gtw_pkg::RST_OUT_CAPACITY;
      row_fill_q     <= '0;
      space_pos_q    <= '0;
      space_seen_q   <= 1'b0;
      rows_done_q    <= '0;
      bytes_done_q   <= '0;
      refused_q      <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      row_fill_q   <= row_fill_d;
      space_pos_q  <= space_pos_d;
      space_seen_q <= space_seen_d;
      rows_done_q  <= rows_done_d;
      bytes_done_q <= bytes_done_d;
      refused_q    <= refused_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        case (cfg_index_i)
          gtw_pkg::CFG_ROW_WIDTH:    row_width_q    <= cfg_data_i[4:0];
          gtw_pkg::CFG_ROW_LIMIT:    row_limit_q    <= cfg_data_i[4:0];
          gtw_pkg::CFG_OUT_CAPACITY: out_capacity_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    c_q    <= c_d;
    fin_q  <= fin_d;
    len_q  <= len_d;
    cnt_q  <= cnt_d;
    post_q <= post_d;
    if (emit) begin
      kind_q  <= kind_d;
      byte_q  <= byte_d;
      count_q <= count_d;
      end_q   <= end_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign out_byte_o  = byte_q;
  assign row_count_o = count_q;
  assign run_end_o   = end_q;

  `GTW_ASSERT(a_rows_bound, rows_done_q <= ROWS_MAX)
  `GTW_ASSERT(a_fill_bound, row_fill_q <= COLS_MAX)
  `GTW_ASSERT(a_row_count, (state_q != ST_ROW) || (cnt_q < len_q))
  `GTW_ASSERT_NEXT(a_accept_dec, in_valid_i && !in_stall_o, state_q == ST_DEC)

endmodule
